// ----- hw/rtl/dewpoint_from_temp_humidity_macros.svh -----
// ----------------------------------------------------------------------------
// dewpoint_from_temp_humidity_macros.svh
// assertion macros for the dewpoint pipeline, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef DEWPOINT_FROM_TEMP_HUMIDITY_MACROS_SVH
`define DEWPOINT_FROM_TEMP_HUMIDITY_MACROS_SVH

`ifndef SYNTHESIS
// consequent checked in the same cycle as the antecedent
`define DPTH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dewpoint pipeline check failed");
// consequent checked in the cycle after the antecedent
`define DPTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dewpoint pipeline check failed");
`else
`define DPTH_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DPTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/dpth_pkg.sv -----
// ----------------------------------------------------------------------------
// dpth_pkg
// constants and elaboration-time helpers for the dewpoint pipeline
// ----------------------------------------------------------------------------
package dpth_pkg;

    localparam int unsigned LogFracBitsDef = 16;
    localparam int unsigned MantBits       = 30;
    localparam longint      Ln2Q30         = 744261118;
    localparam longint      GminMicro      = 70887806;
    localparam int unsigned DewQuoBits     = 17;
    localparam int unsigned Term1IntBits   = 11;
    localparam logic signed [15:0] DewMax  = 16'sh7fff;
    localparam logic signed [15:0] DewMin  = 16'sh8000;

    // log2 of a constant by repeated squaring, same steps as the hardware
    function automatic longint log2_const(input int unsigned v, input int unsigned fb);
        int unsigned     k;
        longint unsigned x;
        longint unsigned frac;
        k = 0;
        for (int i = 0; i < 15; i++) begin
            if ((v >> (i + 1)) != 0) k = i + 1;
        end
        x    = longint'(v) << (MantBits - k);
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            if (i < fb) begin
                x    = (x * x) >> MantBits;
                frac = frac << 1;
                if (x >= (64'd2 << MantBits)) begin
                    x    = x >> 1;
                    frac = frac | 64'd1;
                end
            end
        end
        return longint'((longint'(k) << fb) | frac);
    endfunction

endpackage

// ----- hw/rtl/dpth_if.sv -----
// ----------------------------------------------------------------------------
// dpth_if
// valid/ready channels carrying dewpoint input points and results
// ----------------------------------------------------------------------------
interface dpth_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temp_centi;
    logic               temp_missing;
    logic [15:0]        humidity_centi;
    logic               humidity_missing;
    logic               last_point;

    modport source (output valid, temp_centi, temp_missing, humidity_centi,
                    humidity_missing, last_point, input ready);
    modport sink   (input valid, temp_centi, temp_missing, humidity_centi,
                    humidity_missing, last_point, output ready);
endinterface

interface dpth_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dewpoint_centi;
    logic               dewpoint_missing;
    logic               last_point_out;

    modport source (output valid, dewpoint_centi, dewpoint_missing, last_point_out,
                    input ready);
    modport sink   (input valid, dewpoint_centi, dewpoint_missing, last_point_out,
                    output ready);
endinterface

// ----- hw/rtl/dewpoint_from_temp_humidity.sv -----
// ----------------------------------------------------------------------------
// dewpoint_from_temp_humidity
// Magnus-formula dewpoint from temperature and relative humidity
// ----------------------------------------------------------------------------
// i_in takes one point per item (temperature and humidity in hundredths, each
// with a missing flag, plus a batch-end mark); o_out returns one item per
// point: the dewpoint in hundredths of a degree, saturated to 16 bits, with a
// missing flag and the copied batch-end mark. Results leave in input order.
// The pipeline is made of, in order: an input
// register, one stage per log2 fraction bit, one stage per quotient bit of
// the temperature term divider (LOG_FRACTION_BITS + 11), five arithmetic
// stages, a 17-stage dewpoint divider and the output register.
// Throughput is one item per cycle; every stage is a register advancing
// with the rest, so the pipeline takes a new item each cycle while the
// output register is empty or being taken.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and i_in.ready drops; nothing is lost or repeated.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "dewpoint_from_temp_humidity_macros.svh"

module dewpoint_from_temp_humidity #(
    parameter int unsigned LOG_FRACTION_BITS = dpth_pkg::LogFracBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dpth_in_if.sink     i_in,
    dpth_out_if.source  o_out
);
    import dpth_pkg::*;

    localparam int unsigned F    = LOG_FRACTION_BITS;
    localparam int unsigned LW   = F + 4;
    localparam int unsigned N1W  = F + 27;
    localparam int unsigned D1W  = 23;
    localparam int unsigned Q1W  = F + Term1IntBits;
    localparam int unsigned S1W  = N1W + D1W + 3;
    localparam int unsigned S2W  = LW + 3;
    localparam int unsigned DFW  = F + 5;
    localparam int unsigned PW   = DFW + 31;
    localparam int unsigned T1W  = F + 12;
    localparam int unsigned GW   = F + 13;
    localparam int unsigned DSW  = F + 14;
    localparam int unsigned N2W  = F + 28;
    localparam int unsigned D2W  = F + 13;
    localparam int unsigned CW   = D2W + DewQuoBits;

    localparam longint L10k  = log2_const(10000, F);
    localparam longint C1767 = ((longint'(1767) << F) + 50) / 100;
    localparam longint Gmin  = ((GminMicro << F) + 500000) / 1000000;
    localparam logic signed [GW-1:0] GminNeg = -GW'(Gmin);

    logic w_adv;

    // input register
    logic               r_s0_valid;
    logic signed [15:0] r_s0_t;
    logic [15:0]        r_s0_h;
    logic               r_s0_miss;
    logic               r_s0_last;
    logic               n_s0_miss;

    logic [15:0]        w_tmag;
    logic [F+25:0]      w_mag1;
    logic signed [23:0] w_den1s;
    logic [N1W-1:0]     w_num1;

    logic               w_lg_valid;
    logic [LW-1:0]      w_lg_log;
    logic [S1W-1:0]     w_lg_side;

    logic               w_d1_valid;
    logic [Q1W-1:0]     w_d1_q;
    logic [S2W-1:0]     w_d1_side;
    logic [LW-1:0]      w_d1_log;
    logic               w_d1_neg;
    logic               w_d1_miss;
    logic               w_d1_last;

    // arithmetic stages
    logic                  r_t0_valid;
    logic signed [PW-1:0]  r_t0_prod;
    logic signed [T1W-1:0] r_t0_term1;
    logic                  r_t0_miss;
    logic                  r_t0_last;
    logic signed [DFW-1:0] w_diff;
    logic signed [T1W-1:0] n_t0_term1;

    logic                  r_t1_valid;
    logic signed [DFW-1:0] r_t1_term2;
    logic signed [T1W-1:0] r_t1_term1;
    logic                  r_t1_miss;
    logic                  r_t1_last;
    logic [PW-1:0]         w_pmag;
    logic [PW-1:0]         w_prnd;
    logic [DFW-1:0]        w_q2;

    logic                  r_t2_valid;
    logic signed [GW-1:0]  r_t2_g;
    logic                  r_t2_miss;
    logic                  r_t2_last;
    logic signed [GW-1:0]  n_t2_g;

    logic                  r_t3_valid;
    logic [D2W-1:0]        r_t3_d;
    logic [N2W-2:0]        r_t3_prod;
    logic                  r_t3_neg;
    logic                  r_t3_miss;
    logic                  r_t3_last;
    logic signed [DSW-1:0] n_t3_d;
    logic [GW-2:0]         w_gmag;

    logic                  r_t4_valid;
    logic [N2W-1:0]        r_t4_num;
    logic [D2W-1:0]        r_t4_d;
    logic                  r_t4_neg;
    logic                  r_t4_ovf;
    logic                  r_t4_miss;
    logic                  r_t4_last;
    logic [N2W-1:0]        n_t4_num;

    logic                  w_d2_valid;
    logic [DewQuoBits-1:0] w_d2_q;
    logic [3:0]            w_d2_side;

    logic                  r_out_valid;
    logic signed [15:0]    r_out_dew;
    logic                  r_out_miss;
    logic                  r_out_last;
    logic signed [15:0]    n_out_dew;

    // whole pipeline moves unless a result is held at the output
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;

    assign n_s0_miss = i_in.temp_missing || i_in.humidity_missing
                    || (i_in.temp_centi < -16'sd24000) || (i_in.humidity_centi == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_t    <= i_in.temp_centi;
            r_s0_h    <= i_in.humidity_centi;
            r_s0_miss <= n_s0_miss;
            r_s0_last <= i_in.last_point;
        end
    end

    // temperature term operands: |1767*t|<<F plus half the divisor, 100*(t+24350)
    assign w_tmag  = r_s0_t[15] ? 16'(-r_s0_t) : 16'(r_s0_t);
    assign w_mag1  = ((F+26)'(w_tmag) * (F+26)'(11'd1767)) << F;
    assign w_den1s = (24'(r_s0_t) + 24'sd24350) * 24'sd100;
    assign w_num1  = N1W'(w_mag1) + N1W'(w_den1s[D1W-1:1]);

    dpth_log2_pipe #(
        .FB (F),
        .SW (S1W)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_s0_valid),
        .i_h     (r_s0_h),
        .i_side  ({w_num1, w_den1s[D1W-1:0], r_s0_t[15], r_s0_miss, r_s0_last}),
        .o_valid (w_lg_valid),
        .o_log   (w_lg_log),
        .o_side  (w_lg_side)
    );

    dpth_div_pipe #(
        .NW (N1W),
        .DW (D1W),
        .QB (Q1W),
        .SW (S2W)
    ) u_div_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_lg_valid),
        .i_num   (w_lg_side[S1W-1 -: N1W]),
        .i_den   (w_lg_side[D1W+2:3]),
        .i_side  ({w_lg_log, w_lg_side[2:0]}),
        .o_valid (w_d1_valid),
        .o_quo   (w_d1_q),
        .o_side  (w_d1_side)
    );

    assign w_d1_log  = w_d1_side[S2W-1:3];
    assign w_d1_neg  = w_d1_side[2];
    assign w_d1_miss = w_d1_side[1];
    assign w_d1_last = w_d1_side[0];

    // ln(RH/100) = (log2 h - log2 10000) * ln2
    assign w_diff     = $signed({1'b0, w_d1_log}) - DFW'(L10k);
    assign n_t0_term1 = w_d1_neg ? -$signed({1'b0, w_d1_q}) : $signed({1'b0, w_d1_q});

    // round off the 30 bits added by the Q30 ln2 constant, to nearest, ties away from zero
    assign w_pmag = r_t0_prod[PW-1] ? PW'(-r_t0_prod) : PW'(r_t0_prod);
    assign w_prnd = w_pmag + (PW'(1) << (MantBits - 1));
    assign w_q2   = w_prnd[MantBits +: DFW];

    assign n_t2_g = GW'(r_t1_term1) + GW'(r_t1_term2);

    assign n_t3_d = DSW'(C1767) - DSW'(r_t2_g);
    assign w_gmag = r_t2_g[GW-1] ? (GW-1)'(-r_t2_g) : (GW-1)'(r_t2_g);

    assign n_t4_num = N2W'(r_t3_prod) + N2W'(r_t3_d[D2W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_valid <= 1'b0;
            r_t1_valid <= 1'b0;
            r_t2_valid <= 1'b0;
            r_t3_valid <= 1'b0;
            r_t4_valid <= 1'b0;
        end else if (w_adv) begin
            r_t0_valid <= w_d1_valid;
            r_t1_valid <= r_t0_valid;
            r_t2_valid <= r_t1_valid;
            r_t3_valid <= r_t2_valid;
            r_t4_valid <= r_t3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t0_prod  <= w_diff * $signed(31'(Ln2Q30));
            r_t0_term1 <= n_t0_term1;
            r_t0_miss  <= w_d1_miss;
            r_t0_last  <= w_d1_last;

            r_t1_term2 <= r_t0_prod[PW-1] ? -$signed(w_q2) : $signed(w_q2);
            r_t1_term1 <= r_t0_term1;
            r_t1_miss  <= r_t0_miss;
            r_t1_last  <= r_t0_last;

            r_t2_g     <= n_t2_g;
            r_t2_miss  <= r_t1_miss || (n_t2_g < GminNeg);
            r_t2_last  <= r_t1_last;

            r_t3_d     <= n_t3_d[D2W-1:0];
            r_t3_prod  <= (N2W-1)'(w_gmag) * (N2W-1)'(15'd24350);
            r_t3_neg   <= r_t2_g[GW-1];
            r_t3_miss  <= r_t2_miss || n_t3_d[DSW-1] || (n_t3_d == '0);
            r_t3_last  <= r_t2_last;

            r_t4_num   <= n_t4_num;
            r_t4_d     <= r_t3_d;
            r_t4_neg   <= r_t3_neg;
            // quotient too wide for the divider: saturates anyway
            r_t4_ovf   <= CW'(n_t4_num) >= (CW'(r_t3_d) << DewQuoBits);
            r_t4_miss  <= r_t3_miss;
            r_t4_last  <= r_t3_last;
        end
    end

    dpth_div_pipe #(
        .NW (N2W),
        .DW (D2W),
        .QB (DewQuoBits),
        .SW (4)
    ) u_div_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_t4_valid),
        .i_num   (r_t4_num),
        .i_den   (r_t4_d),
        .i_side  ({r_t4_neg, r_t4_ovf, r_t4_miss, r_t4_last}),
        .o_valid (w_d2_valid),
        .o_quo   (w_d2_q),
        .o_side  (w_d2_side)
    );

    // sign, saturation, missing result forced to zero
    always_comb begin
        n_out_dew = '0;
        if (!w_d2_side[1]) begin
            if (w_d2_side[2]) begin
                n_out_dew = w_d2_side[3] ? DewMin : DewMax;
            end else if (w_d2_side[3]) begin
                if (w_d2_q > 17'd32768) n_out_dew = DewMin;
                else                    n_out_dew = 16'(~w_d2_q + 17'd1);
            end else begin
                if (w_d2_q > 17'd32767) n_out_dew = DewMax;
                else                    n_out_dew = 16'(w_d2_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_dew  <= n_out_dew;
            r_out_miss <= w_d2_side[1];
            r_out_last <= w_d2_side[0];
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.dewpoint_centi   = r_out_dew;
    assign o_out.dewpoint_missing = r_out_miss;
    assign o_out.last_point_out   = r_out_last;

    `DPTH_ASSERT_SAME(a_miss_is_zero, i_clk, i_rst_n, r_out_valid && r_out_miss, r_out_dew == '0)
    `DPTH_ASSERT_NEXT(a_held_result_stays, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_out_valid)
    `DPTH_ASSERT_SAME(a_den_nonzero, i_clk, i_rst_n, r_t3_valid && !r_t3_miss, r_t3_d != '0)
    `DPTH_ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !o_out.ready, !w_adv)

endmodule

// ----- hw/rtl/dpth_log2_pipe.sv -----
// ----------------------------------------------------------------------------
// dpth_log2_pipe
// pipelined log2 of a 16-bit value, one fraction bit per stage by squaring
// ----------------------------------------------------------------------------
module dpth_log2_pipe #(
    parameter int unsigned FB = dpth_pkg::LogFracBitsDef,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  logic [15:0]   i_h,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [FB+3:0] o_log,
    output logic [SW-1:0] o_side
);
    import dpth_pkg::*;

    localparam int unsigned XW = MantBits + 1;

    logic [3:0]    w_k;
    logic [XW-1:0] w_x0;

    logic          r_valid [FB];
    logic [XW-1:0] r_x     [FB];
    logic [FB-1:0] r_frac  [FB];
    logic [3:0]    r_k     [FB];
    logic [SW-1:0] r_side  [FB];

    // leading one position, mantissa in [1,2)
    always_comb begin
        w_k = '0;
        for (int i = 1; i < 16; i++) begin
            if (i_h[i]) w_k = 4'(i);
        end
    end

    assign w_x0 = XW'(i_h) << (5'(MantBits) - {1'b0, w_k});

    for (genvar s = 0; s < FB; s++) begin : g_stage
        logic [XW-1:0]   w_xin;
        logic [FB-1:0]   w_fin;
        logic [3:0]      w_kin;
        logic [SW-1:0]   w_sin;
        logic            w_vin;
        logic [2*XW-1:0] w_sq;
        logic [XW-1:0]   n_x;
        logic [FB-1:0]   n_frac;

        if (s == 0) begin : g_first
            assign w_xin = w_x0;
            assign w_fin = '0;
            assign w_kin = w_k;
            assign w_sin = i_side;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_xin = r_x[s-1];
            assign w_fin = r_frac[s-1];
            assign w_kin = r_k[s-1];
            assign w_sin = r_side[s-1];
            assign w_vin = r_valid[s-1];
        end

        assign w_sq   = w_xin * w_xin;
        // square at or above two: halve and emit a one
        assign n_x    = w_sq[2*XW-1] ? w_sq[2*XW-1:XW] : w_sq[2*XW-2:XW-1];
        assign n_frac = {w_fin[FB-2:0], w_sq[2*XW-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_adv) begin
                r_valid[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[s]    <= n_x;
                r_frac[s] <= n_frac;
                r_k[s]    <= w_kin;
                r_side[s] <= w_sin;
            end
        end
    end

    assign o_valid = r_valid[FB-1];
    assign o_log   = {r_k[FB-1], r_frac[FB-1]};
    assign o_side  = r_side[FB-1];

endmodule

// ----- hw/rtl/dpth_div_pipe.sv -----
// ----------------------------------------------------------------------------
// dpth_div_pipe
// pipelined restoring divider, one quotient bit per stage, msb first
// ----------------------------------------------------------------------------
module dpth_div_pipe #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 16,
    parameter int unsigned QB = 16,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int unsigned WW = (NW > DW + QB) ? NW : DW + QB;

    logic          r_valid [QB];
    logic [NW-1:0] r_rem   [QB];
    logic [DW-1:0] r_den   [QB];
    logic [QB-1:0] r_q     [QB];
    logic [SW-1:0] r_side  [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [NW-1:0] w_rin;
        logic [DW-1:0] w_din;
        logic [QB-1:0] w_qin;
        logic [SW-1:0] w_sin;
        logic          w_vin;
        logic [WW-1:0] w_sub;
        logic          w_ge;
        logic [NW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_rin = i_num;
            assign w_din = i_den;
            assign w_qin = '0;
            assign w_sin = i_side;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_rin = r_rem[s-1];
            assign w_din = r_den[s-1];
            assign w_qin = r_q[s-1];
            assign w_sin = r_side[s-1];
            assign w_vin = r_valid[s-1];
        end

        assign w_sub = WW'(w_din) << (QB - 1 - s);
        assign w_ge  = WW'(w_rin) >= w_sub;
        assign n_rem = w_ge ? NW'(WW'(w_rin) - w_sub) : w_rin;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_adv) begin
                r_valid[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= w_din;
                r_q[s]    <= {w_qin[QB-2:0], w_ge};
                r_side[s] <= w_sin;
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_quo   = r_q[QB-1];
    assign o_side  = r_side[QB-1];

endmodule
